FILE: design/rgdp_pkg.sv
// Shared types and constants for the RGB gray ordered-dither packer.
`default_nettype none
package rgdp_pkg;

	localparam int PHASE_COUNT = 4;
	localparam int LEVEL_COUNT = 256;

	localparam int PHASE_W    = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
	localparam int LEVEL_W    = $clog2(LEVEL_COUNT);
	localparam int DITH_DEPTH = PHASE_COUNT * LEVEL_COUNT;
	localparam int DITH_AW    = $clog2(DITH_DEPTH);

	localparam int WEIGHT_W    = 16;
	localparam int WEIGHT_DEPTH = 256;
	localparam int SUM_W       = 18;
	localparam int RAW_W       = 10;
	localparam int ENTRY_W     = 8;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 3;

	typedef enum logic [2:0] {
		ACT_PIXEL  = 3'd0,
		ACT_DITHER = 3'd1,
		ACT_RED    = 3'd2,
		ACT_GREEN  = 3'd3,
		ACT_BLUE   = 3'd4
	} action_t;

	localparam logic [2:0] OW_1 = 3'd0;
	localparam logic [2:0] OW_2 = 3'd1;
	localparam logic [2:0] OW_4 = 3'd2;
	localparam logic [2:0] OW_8 = 3'd3;

	localparam logic [CFG_IW-1:0] CFG_OUTPUT_WIDTH    = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_FIRST_PIXEL_HIGH = 1'b1;

	localparam logic [2:0] OUTPUT_WIDTH_RESET = OW_8;

	typedef struct packed {
		logic valid;
		logic line_end;
	} s2_ctl_t;

endpackage
`default_nettype wire

FILE: design/rgdp_ram.sv
// Generic simple dual-port RAM with registered, enabled read.
`default_nettype none
module rgdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/rgdp_lookup.sv
// Weight and dither table lookup: weight read, level sum, dither read and phase.
`default_nettype none
module rgdp_lookup (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           acc,
	input  wire logic [2:0]                     action,
	input  wire logic [7:0]                     red,
	input  wire logic [7:0]                     green,
	input  wire logic [7:0]                     blue,
	input  wire logic                           end_of_line,
	input  wire logic [1:0]                     load_phase,
	input  wire logic [7:0]                     load_index,
	input  wire logic [15:0]                    load_value,
	input  wire logic                           s2_free,
	output logic                                busy_s1,
	output rgdp_pkg::s2_ctl_t                   ctl_s2,
	output logic      [rgdp_pkg::ENTRY_W-1:0]   entry_s2
);
	import rgdp_pkg::*;

	logic                  v_s1;
	logic                  pix_s1;
	logic                  eol_s1;
	logic [1:0]            lphase_s1;
	logic [7:0]            lindex_s1;
	logic [ENTRY_W-1:0]    lvalue_s1;
	logic [PHASE_W-1:0]    phase_q;
	logic                  ctl_v_s2;
	logic                  ctl_eol_s2;

	logic                  is_pix;
	logic                  is_dith;
	logic                  en1;
	logic                  mv1;
	logic                  acc_pix;
	logic [WEIGHT_W-1:0]   rw;
	logic [WEIGHT_W-1:0]   gw;
	logic [WEIGHT_W-1:0]   bw;
	logic [SUM_W-1:0]      sum;
	logic [RAW_W-1:0]      raw;
	logic [LEVEL_W-1:0]    level;
	logic [DITH_AW-1:0]    rd_addr;
	logic [DITH_AW-1:0]    wr_addr;
	logic                  dith_we;
	logic                  dith_re;

	assign is_pix  = (action == ACT_PIXEL);
	assign is_dith = (action == ACT_DITHER);
	assign acc_pix = acc && is_pix;
	assign en1     = !v_s1 || s2_free;
	assign mv1     = v_s1 && s2_free;
	assign busy_s1 = v_s1;

	rgdp_ram #(.WIDTH(WEIGHT_W), .DEPTH(WEIGHT_DEPTH)) u_red_ram (
		.clk  (clk),
		.we   (acc && (action == ACT_RED)),
		.waddr(load_index),
		.wdata(load_value),
		.re   (acc_pix),
		.raddr(red),
		.rdata(rw)
	);

	rgdp_ram #(.WIDTH(WEIGHT_W), .DEPTH(WEIGHT_DEPTH)) u_green_ram (
		.clk  (clk),
		.we   (acc && (action == ACT_GREEN)),
		.waddr(load_index),
		.wdata(load_value),
		.re   (acc_pix),
		.raddr(green),
		.rdata(gw)
	);

	rgdp_ram #(.WIDTH(WEIGHT_W), .DEPTH(WEIGHT_DEPTH)) u_blue_ram (
		.clk  (clk),
		.we   (acc && (action == ACT_BLUE)),
		.waddr(load_index),
		.wdata(load_value),
		.re   (acc_pix),
		.raddr(blue),
		.rdata(bw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= acc && (is_pix || is_dith);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && en1) begin
			pix_s1    <= is_pix;
			eol_s1    <= end_of_line;
			lphase_s1 <= load_phase;
			lindex_s1 <= load_index;
			lvalue_s1 <= load_value[ENTRY_W-1:0];
		end
	end

	// level = weight sum / 256, saturated at the top level
	always_comb begin
		sum   = SUM_W'(rw) + SUM_W'(gw) + SUM_W'(bw);
		raw   = sum[SUM_W-1:SUM_W-RAW_W];
		if (raw > RAW_W'(LEVEL_COUNT - 1)) begin
			level = LEVEL_W'(LEVEL_COUNT - 1);
		end else begin
			level = raw[LEVEL_W-1:0];
		end
		rd_addr = DITH_AW'(phase_q) * DITH_AW'(LEVEL_COUNT) + DITH_AW'(level);
		wr_addr = DITH_AW'(lphase_s1) * DITH_AW'(LEVEL_COUNT) + DITH_AW'(lindex_s1);
	end

	// loads write in order with pixel reads, at the same stage
	assign dith_we = mv1 && !pix_s1 && (32'(lphase_s1) < PHASE_COUNT)
		&& (32'(lindex_s1) < LEVEL_COUNT);
	assign dith_re = mv1 && pix_s1;

	rgdp_ram #(.WIDTH(ENTRY_W), .DEPTH(DITH_DEPTH)) u_dither_ram (
		.clk  (clk),
		.we   (dith_we),
		.waddr(wr_addr),
		.wdata(lvalue_s1),
		.re   (dith_re),
		.raddr(rd_addr),
		.rdata(entry_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (dith_re) begin
			if (eol_s1 || (phase_q == PHASE_W'(PHASE_COUNT - 1))) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_q + PHASE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_v_s2 <= 1'b0;
		end else if (s2_free) begin
			ctl_v_s2 <= dith_re;
		end
	end

	always_ff @(posedge clk) begin
		if (dith_re) begin
			ctl_eol_s2 <= eol_s1;
		end
	end

	assign ctl_s2 = '{valid: ctl_v_s2, line_end: ctl_eol_s2};

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(phase_q) < PHASE_COUNT)
		else $error("dither phase out of range");

	a_one_dither_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(dith_we && dith_re))
		else $error("dither write and read in one cycle");

	a_pixel_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_pix && en1) |=> (v_s1 && pix_s1))
		else $error("accepted pixel missing from first stage");

endmodule
`default_nettype wire

FILE: design/rgdp_pack.sv
// Bit packer, configuration registers and output register.
`default_nettype none
module rgdp_pack (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [rgdp_pkg::CFG_IW-1:0]  cfg_idx,
	input  wire logic [rgdp_pkg::CFG_DW-1:0]  cfg_val,
	input  wire rgdp_pkg::s2_ctl_t            ctl_s2,
	input  wire logic [rgdp_pkg::ENTRY_W-1:0] entry_s2,
	output logic                              ready,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [15:0]                  out_word,
	output logic                              out_line_end
);
	import rgdp_pkg::*;

	logic [2:0]         ow_q;
	logic               fph_q;
	logic [7:0]         byte_q;
	logic [2:0]         fill_q;
	logic               out_valid_q;
	logic [15:0]        word_q;
	logic               line_end_q;

	logic               consume;
	logic               wide;
	logic [1:0]         sh_log;
	logic [3:0]         slots;
	logic [3:0]         fill_n;
	logic [3:0]         sh_lo;
	logic [3:0]         sh_hi;
	logic [2:0]         sh;
	logic [7:0]         mask;
	logic [7:0]         bits;
	logic [7:0]         byte_n;
	logic               emit;

	assign ready   = !out_valid_q || !out_stall;
	assign consume = ctl_s2.valid && ready;
	assign wide    = (ow_q >= OW_8);
	assign sh_log  = ow_q[1:0];

	always_comb begin
		unique case (sh_log)
			2'd0:    mask = 8'h01;
			2'd1:    mask = 8'h03;
			default: mask = 8'h0F;
		endcase
		slots  = 4'd8 >> sh_log;
		fill_n = {1'b0, fill_q} + 4'd1;
		sh_lo  = {1'b0, fill_q} << sh_log;
		sh_hi  = 4'd8 - (fill_n << sh_log);
		sh     = fph_q ? sh_hi[2:0] : sh_lo[2:0];
		bits   = entry_s2 & mask;
		byte_n = byte_q | (bits << sh);
		emit   = wide || (fill_n == slots) || ctl_s2.line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= OUTPUT_WIDTH_RESET;
			fph_q  <= 1'b0;
			byte_q <= '0;
			fill_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_OUTPUT_WIDTH:     ow_q  <= cfg_val;
				CFG_FIRST_PIXEL_HIGH: fph_q <= cfg_val[0];
				default:              ;
			endcase
			byte_q <= '0;
			fill_q <= '0;
		end else if (consume && !wide) begin
			if (emit) begin
				byte_q <= '0;
				fill_q <= '0;
			end else begin
				byte_q <= byte_n;
				fill_q <= fill_n[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready) begin
			out_valid_q <= consume && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			word_q     <= wide ? {8'h00, entry_s2} : {8'h00, byte_n};
			line_end_q <= ctl_s2.line_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = word_q;
	assign out_line_end = line_end_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((ow_q != OW_2) || (fill_q < 3'd4)) && ((ow_q != OW_4) || (fill_q < 3'd2)))
		else $error("pack fill beyond byte");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |=> out_valid_q)
		else $error("stalled result lost");

endmodule
`default_nettype wire

FILE: design/rgb_gray_ordered_dither_packer_core.sv
// Top level of the RGB gray ordered-dither packer.
//
//  channel  dir  handshake                fields
//  in       in   in_valid / in_stall      action red green blue end_of_line
//                                         load_phase load_index load_value
//  out      out  out_valid / out_stall    out_word out_line_end
//  cfg      in   cfg_valid / cfg_ready    cfg_index cfg_data
//
// One item per cycle while in_stall is low; a pixel passes the weight RAM read at the edge that
// takes it, the dither RAM read and the packer's output register, each RAM port once a cycle.
// Loads take the same slots, writing weights at once and dither entries as they leave the first stage.
// Reset clears control, phase and packing state; table RAMs are not cleared.
// in_stall rises only when every stage is full and the output is stalled.
`default_nettype none
module rgb_gray_ordered_dither_packer_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   action,
	input  wire logic [7:0]                   red,
	input  wire logic [7:0]                   green,
	input  wire logic [7:0]                   blue,
	input  wire logic                         end_of_line,
	input  wire logic [1:0]                   load_phase,
	input  wire logic [7:0]                   load_index,
	input  wire logic [15:0]                  load_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [15:0]                  out_word,
	output logic                              out_line_end,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rgdp_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [rgdp_pkg::CFG_DW-1:0]  cfg_data
);
	import rgdp_pkg::*;

	logic               busy_s1;
	logic               pack_ready;
	logic               s2_free;
	logic               acc;
	s2_ctl_t            ctl_s2;
	logic [ENTRY_W-1:0] entry_s2;

	assign cfg_ready = 1'b1;
	assign s2_free   = !ctl_s2.valid || pack_ready;
	assign in_stall  = busy_s1 && !s2_free;
	assign acc       = in_valid && !in_stall;

	rgdp_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.action     (action),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.end_of_line(end_of_line),
		.load_phase (load_phase),
		.load_index (load_index),
		.load_value (load_value),
		.s2_free    (s2_free),
		.busy_s1    (busy_s1),
		.ctl_s2     (ctl_s2),
		.entry_s2   (entry_s2)
	);

	rgdp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_val     (cfg_data),
		.ctl_s2      (ctl_s2),
		.entry_s2    (entry_s2),
		.ready       (pack_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.out_line_end(out_line_end)
	);

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && ctl_s2.valid))
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
